@@ rtl/core/glcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcc_pkg
// shared types, constants and colour functions of the gesture led controller
// ----------------------------------------------------------------------------
package glcc_pkg;

    localparam int TOUCH_W      = 4;
    localparam int LED_NUM_W    = 3;
    localparam int COLOUR_W     = 8;
    localparam int LEVEL_W      = 5;
    localparam int HUE_W        = 9;
    localparam int DIV_W        = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int TOUCH_LEDS   = 4;
    localparam int PALETTE_W    = 3;
    localparam int SLOTS        = 6;
    localparam int SLOT_W       = 3;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;
    localparam int QUEUE_CNT_W  = 3;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_BRIGHTNESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HUE_STEP       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_DIVIDER = 2'd2;

    localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST = 5'd15;
    localparam logic [HUE_W-1:0]   HUE_STEP_RST   = 9'd10;
    localparam logic [DIV_W-1:0]   DIVIDER_RST    = 8'd5;

    localparam logic [LED_NUM_W-1:0] LED_CW  = 3'd4;
    localparam logic [LED_NUM_W-1:0] LED_CCW = 3'd5;

    localparam logic [PALETTE_W-1:0] PALETTE_LAST = 3'd5;

    typedef enum logic [1:0] {
        WHEEL_NONE,
        WHEEL_OFF,
        WHEEL_UPDATE
    } wheel_op_t;

    typedef logic [PALETTE_W-1:0] palette_pos_t;

    // one classified tick, as handed from the front to the back
    typedef struct packed {
        logic [TOUCH_LEDS-1:0]              touch_mask; // bit i: led i pressed
        palette_pos_t [TOUCH_LEDS-1:0]      pos;
        wheel_op_t                          wheel_op;
        logic                               clockwise;
        logic [HUE_W-1:0]                   hue;
    } glcc_cmd_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } rgb_t;

    function automatic rgb_t palette_rgb(input palette_pos_t pos);
        rgb_t c;
        case (pos)
            3'd0:    c = '{8'd255, 8'd0,   8'd0};
            3'd1:    c = '{8'd255, 8'd127, 8'd0};
            3'd2:    c = '{8'd255, 8'd255, 8'd0};
            3'd3:    c = '{8'd0,   8'd255, 8'd0};
            3'd4:    c = '{8'd0,   8'd0,   8'd255};
            3'd5:    c = '{8'd127, 8'd0,   8'd255};
            default: c = '{8'd255, 8'd0,   8'd0};
        endcase
        return c;
    endfunction

    // full saturation, full value; hue is below 360
    function automatic rgb_t hue_to_rgb(input logic [HUE_W-1:0] h);
        logic [2:0]          region;
        logic [HUE_W-1:0]    base;
        logic [5:0]          rem60;
        logic [9:0]          scaled;
        logic [COLOUR_W-1:0] r;
        logic [COLOUR_W-1:0] rn;
        rgb_t                c;
        if (h >= 9'd300)
        begin
            region = 3'd5;
            base   = 9'd300;
        end
        else if (h >= 9'd240)
        begin
            region = 3'd4;
            base   = 9'd240;
        end
        else if (h >= 9'd180)
        begin
            region = 3'd3;
            base   = 9'd180;
        end
        else if (h >= 9'd120)
        begin
            region = 3'd2;
            base   = 9'd120;
        end
        else if (h >= 9'd60)
        begin
            region = 3'd1;
            base   = 9'd60;
        end
        else
        begin
            region = 3'd0;
            base   = 9'd0;
        end
        rem60  = 6'(h - base);
        // x * 255 / 60 is x * 17 / 4
        scaled = 10'({4'd0, rem60} * 10'd17) >> 2;
        r      = scaled[COLOUR_W-1:0];
        rn     = 8'd255 - r;
        case (region)
            3'd0:    c = '{8'd255, r,      8'd0};
            3'd1:    c = '{rn,     8'd255, 8'd0};
            3'd2:    c = '{8'd0,   8'd255, r};
            3'd3:    c = '{8'd0,   rn,     8'd255};
            3'd4:    c = '{r,      8'd0,   8'd255};
            default: c = '{8'd255, 8'd0,   rn};
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/glcc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcc_if
// valid/ready channels for poll ticks and led writes
// ----------------------------------------------------------------------------
interface glcc_tick_if;
    import glcc_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOUCH_W-1:0] touch_bits;
    logic               wheel_active;
    logic               wheel_clockwise;

    modport source (output valid, output touch_bits, output wheel_active,
                    output wheel_clockwise, input ready);
    modport sink   (input valid, input touch_bits, input wheel_active,
                    input wheel_clockwise, output ready);
endinterface

interface glcc_led_if;
    import glcc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [LED_NUM_W-1:0] led_number;
    logic [COLOUR_W-1:0]  red_level;
    logic [COLOUR_W-1:0]  green_level;
    logic [COLOUR_W-1:0]  blue_level;
    logic [LEVEL_W-1:0]   led_level;
    logic                 final_write;

    modport source (output valid, output led_number, output red_level,
                    output green_level, output blue_level, output led_level,
                    output final_write, input ready);
    modport sink   (input valid, input led_number, input red_level,
                    input green_level, input blue_level, input led_level,
                    input final_write, output ready);
endinterface

@@ rtl/core/gesture_led_color_controller_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_led_color_controller_top
// touch and airwheel driven led colour controller
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake     payload
//  tick      in         valid/ready   touch_bits, wheel_active, wheel_clockwise
//  led       out        valid/ready   led_number, rgb levels, led_level,
//                                     final_write
//  cfg       in         write enable  cfg_index, cfg_data
//
//  a tick transaction is taken whenever the 4-entry queue has room
//  the back emits one led write per cycle while the led sink is ready; a tick
//  causes 0 to 6 writes; ticks with no writes take no queue entry but
//  still wait while the queue is full
//  the led output register parts the two sides: a stalled led sink only fills
//  the queue, after which tick ready drops
//  rst_n is asynchronous, active low; it clears history, palette positions,
//  hue, divider and the registers to their defaults
//
module gesture_led_color_controller_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    glcc_tick_if.sink                         tick,
    glcc_led_if.source                        led,
    input  logic                              cfg_write_en,
    input  logic [glcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [glcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import glcc_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0]  brightness_reg;
    logic [HUE_W-1:0]    hue_step_reg;
    logic [DIV_W-1:0]    divider_reg;

    // front to queue
    logic                push;
    glcc_cmd_t           push_cmd;
    logic                queue_full;

    // queue to back
    logic                pop;
    logic                head_valid;
    glcc_cmd_t           head_cmd;

    // register writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RST;
            hue_step_reg   <= HUE_STEP_RST;
            divider_reg    <= DIVIDER_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_LED_BRIGHTNESS: brightness_reg <= cfg_data[LEVEL_W-1:0];
                CFG_HUE_STEP:       hue_step_reg   <= cfg_data[HUE_W-1:0];
                CFG_UPDATE_DIVIDER: divider_reg    <= cfg_data[DIV_W-1:0];
                default:            brightness_reg <= brightness_reg;
            endcase
        end
    end

    // front: edge detection, palette stepping, wheel state and hue divider
    glcc_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .hue_step       (hue_step_reg),
        .update_divider (divider_reg),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // queue: only ticks that cause at least one write are stored
    glcc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back: hue to colour, write sequencing and the output register
    glcc_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_cmd       (head_cmd),
        .pop            (pop),
        .led_brightness (brightness_reg),
        .led            (led)
    );

endmodule

@@ rtl/core/glcc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcc_front
// takes poll ticks, tracks edges, palette positions, hue and divider
// ----------------------------------------------------------------------------
module glcc_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    glcc_tick_if.sink                    tick,
    input  logic [glcc_pkg::HUE_W-1:0]   hue_step,
    input  logic [glcc_pkg::DIV_W-1:0]   update_divider,
    input  logic                         queue_full,
    output logic                         push,
    output glcc_pkg::glcc_cmd_t          push_cmd
);
    import glcc_pkg::*;

    logic [TOUCH_W-1:0]                  touch_hist_reg;
    logic [TOUCH_W-1:0]                  touch_hist_next;
    palette_pos_t [TOUCH_LEDS-1:0]       pos_reg;
    palette_pos_t [TOUCH_LEDS-1:0]       pos_next;
    logic [HUE_W-1:0]                    hue_reg;
    logic [HUE_W-1:0]                    hue_next;
    logic [DIV_W-1:0]                    tick_cnt_reg;
    logic [DIV_W-1:0]                    tick_cnt_next;
    logic                                wheel_hist_reg;
    logic                                wheel_hist_next;

    logic                                accept;
    logic [TOUCH_W-1:0]                  pressed;
    logic [TOUCH_LEDS-1:0]               led_mask;
    logic [HUE_W-1:0]                    base_hue;
    logic [DIV_W-1:0]                    tick_inc;
    logic [DIV_W-1:0]                    div_eff;
    logic [HUE_W:0]                      hue_sum;
    logic [HUE_W:0]                      hue_wrap;
    wheel_op_t                           op;

    assign tick.ready = !queue_full;
    assign accept     = tick.valid && !queue_full;

    always_comb
    begin
        // edges reordered north, east, south, west
        pressed  = tick.touch_bits & ~touch_hist_reg;
        led_mask = {pressed[1], pressed[0], pressed[3], pressed[2]};

        for (int i = 0; i < TOUCH_LEDS; i++)
        begin
            if (led_mask[i])
                pos_next[i] = (pos_reg[i] >= PALETTE_LAST) ? '0
                                                            : pos_reg[i] + 3'd1;
            else
                pos_next[i] = pos_reg[i];
        end

        base_hue = (tick.wheel_active && !wheel_hist_reg) ? '0 : hue_reg;
        tick_inc = tick_cnt_reg + 8'd1;
        div_eff  = (update_divider == '0) ? 8'd1 : update_divider;
        hue_sum  = {1'b0, base_hue} + {1'b0, hue_step};
        if (hue_sum >= 10'd720)
            hue_wrap = hue_sum - 10'd720;
        else if (hue_sum >= 10'd360)
            hue_wrap = hue_sum - 10'd360;
        else
            hue_wrap = hue_sum;

        op              = WHEEL_NONE;
        hue_next        = hue_reg;
        tick_cnt_next   = tick_cnt_reg;
        wheel_hist_next = tick.wheel_active;
        if (!tick.wheel_active && wheel_hist_reg)
        begin
            op = WHEEL_OFF;
        end
        else if (tick.wheel_active)
        begin
            if (tick_inc >= div_eff)
            begin
                tick_cnt_next = '0;
                hue_next      = hue_wrap[HUE_W-1:0];
                op            = WHEEL_UPDATE;
            end
            else
            begin
                tick_cnt_next = tick_inc;
                hue_next      = base_hue;
            end
        end
        touch_hist_next = tick.touch_bits;
    end

    assign push                = accept && ((led_mask != '0) || (op != WHEEL_NONE));
    assign push_cmd.touch_mask = led_mask;
    assign push_cmd.pos        = pos_next;
    assign push_cmd.wheel_op   = op;
    assign push_cmd.clockwise  = tick.wheel_clockwise;
    assign push_cmd.hue        = hue_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_hist_reg <= '0;
            pos_reg        <= '0;
            hue_reg        <= '0;
            tick_cnt_reg   <= '0;
            wheel_hist_reg <= 1'b0;
        end
        else if (accept)
        begin
            touch_hist_reg <= touch_hist_next;
            pos_reg        <= pos_next;
            hue_reg        <= hue_next;
            tick_cnt_reg   <= tick_cnt_next;
            wheel_hist_reg <= wheel_hist_next;
        end
    end

endmodule

@@ rtl/core/glcc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcc_queue
// short fifo of classified ticks between front and back
// ----------------------------------------------------------------------------
module glcc_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  glcc_pkg::glcc_cmd_t  push_cmd,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output glcc_pkg::glcc_cmd_t  head_cmd
);
    import glcc_pkg::*;

    glcc_cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]    count_reg;
    logic [QUEUE_CNT_W-1:0]    count_next;
    logic                      do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/glcc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcc_back
// expands a classified tick into led writes, one per cycle while the led sink is ready
// ----------------------------------------------------------------------------
module glcc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  glcc_pkg::glcc_cmd_t           head_cmd,
    output logic                          pop,
    input  logic [glcc_pkg::LEVEL_W-1:0]  led_brightness,
    glcc_led_if.source                    led
);
    import glcc_pkg::*;

    // slots 0..3 touch leds, 4 first wheel write, 5 second wheel write
    logic [SLOTS-1:0]                pend_reg;
    logic [SLOTS-1:0]                pend_next;
    palette_pos_t [TOUCH_LEDS-1:0]   pos_reg;
    rgb_t                            wheel_rgb_reg;
    logic                            cw_reg;
    logic                            lit_reg;

    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [LED_NUM_W-1:0]            out_num_reg;
    logic [LED_NUM_W-1:0]            out_num_next;
    rgb_t                            out_rgb_reg;
    rgb_t                            out_rgb_next;
    logic [LEVEL_W-1:0]              out_level_reg;
    logic [LEVEL_W-1:0]              out_level_next;
    logic                            out_final_reg;

    logic                            advance;
    logic                            emit;
    logic [SLOT_W-1:0]               sel;
    logic [SLOTS-1:0]                rest;
    logic                            load;
    logic                            wheel_any;

    assign advance   = !out_valid_reg || led.ready;
    assign emit      = advance && (pend_reg != '0);
    assign rest      = pend_reg & (pend_reg - 1'b1);
    assign load      = head_valid && ((pend_reg == '0) || (emit && (rest == '0)));
    assign pop       = load;
    assign wheel_any = (head_cmd.wheel_op != WHEEL_NONE);

    always_comb
    begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                sel = SLOT_W'(i);
        end
    end

    always_comb
    begin
        if (load)
            pend_next = {wheel_any, wheel_any, head_cmd.touch_mask};
        else if (emit)
            pend_next = rest;
        else
            pend_next = pend_reg;

        out_valid_next = emit ? 1'b1 : (advance ? 1'b0 : out_valid_reg);
    end

    always_comb
    begin
        out_num_next   = LED_CW;
        out_rgb_next   = '0;
        out_level_next = '0;
        case (sel)
            3'd0, 3'd1, 3'd2, 3'd3:
            begin
                out_num_next   = sel;
                out_rgb_next   = palette_rgb(pos_reg[sel[1:0]]);
                out_level_next = led_brightness;
            end
            3'd4:
            begin
                if (lit_reg)
                begin
                    out_num_next   = cw_reg ? LED_CW : LED_CCW;
                    out_rgb_next   = wheel_rgb_reg;
                    out_level_next = led_brightness;
                end
                else
                begin
                    out_num_next = LED_CW;
                end
            end
            3'd5:
            begin
                out_num_next = (lit_reg && !cw_reg) ? LED_CW : LED_CCW;
            end
            default:
            begin
                out_num_next = LED_CW;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pos_reg       <= head_cmd.pos;
            wheel_rgb_reg <= hue_to_rgb(head_cmd.hue);
            cw_reg        <= head_cmd.clockwise;
            lit_reg       <= (head_cmd.wheel_op == WHEEL_UPDATE);
        end
        if (emit)
        begin
            out_num_reg   <= out_num_next;
            out_rgb_reg   <= out_rgb_next;
            out_level_reg <= out_level_next;
            out_final_reg <= (rest == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign led.valid       = out_valid_reg;
    assign led.led_number  = out_num_reg;
    assign led.red_level   = out_rgb_reg.red;
    assign led.green_level = out_rgb_reg.green;
    assign led.blue_level  = out_rgb_reg.blue;
    assign led.led_level   = out_level_reg;
    assign led.final_write = out_final_reg;

endmodule

@@ rtl/core/glcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glcc_checker
// port level checks on the led write stream
// ----------------------------------------------------------------------------
module glcc_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               led_valid,
    input  logic                               led_ready,
    input  logic [glcc_pkg::LED_NUM_W-1:0]     led_number,
    input  logic [glcc_pkg::COLOUR_W-1:0]      red_level,
    input  logic [glcc_pkg::COLOUR_W-1:0]      green_level,
    input  logic [glcc_pkg::COLOUR_W-1:0]      blue_level,
    input  logic                               final_write
);
    import glcc_pkg::*;

    // a stalled write keeps its led and its last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && !led_ready |=> led_valid && $stable(led_number)
                                    && $stable(final_write))
    else $error("led write changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        led_valid |-> led_number <= LED_CCW)
    else $error("led number out of range");

    // black is only ever written to a wheel led being switched off
    assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && red_level == '0 && green_level == '0 && blue_level == '0
        |-> led_number == LED_CW || led_number == LED_CCW)
    else $error("touch led written black");

    // writes of one tick leave back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        led_valid && led_ready && !final_write |=> led_valid)
    else $error("gap inside the writes of one tick");

endmodule

bind gesture_led_color_controller_top glcc_checker u_glcc_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .led_valid   (led.valid),
    .led_ready   (led.ready),
    .led_number  (led.led_number),
    .red_level   (led.red_level),
    .green_level (led.green_level),
    .blue_level  (led.blue_level),
    .final_write (led.final_write)
);
